// ===== sv/voice_allocator_oldest_steal_macros.svh =====
// assertion macros for the voice allocator
`ifndef VOICE_ALLOCATOR_OLDEST_STEAL_MACROS_SVH
`define VOICE_ALLOCATOR_OLDEST_STEAL_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define VAOS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define VAOS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/vaos_pkg.sv =====
// shared types and constants of the voice allocator
package vaos_pkg;

	localparam int CMD_W      = 2;
	localparam int SLOT_W     = 6;
	localparam int VOICE_W    = 6;
	localparam int CFG_W      = 7;
	localparam int STAMP_W    = 64;
	localparam int PLAYER_CAP = 64;

	localparam logic [CFG_W-1:0] MAX_VOICES_RESET = 7'd10;

	localparam logic [CMD_W-1:0] CMD_PLAY   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FINISH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP   = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SLOT_W-1:0] slot;
	} vaos_req_t;

	typedef struct packed {
		logic               granted;
		logic [VOICE_W-1:0] voice;
		logic               stolen;
		logic               any_playing;
	} vaos_rsp_t;

	typedef struct packed {
		logic load_req;
		logic idx_clr;
		logic idx_inc;
		logic rd_en;
		logic pick_free;
		logic steal_mark;
		logic commit;
	} vaos_ctl_t;

	typedef struct packed {
		logic is_play;
		logic cur_idle;
		logic idx_last;
	} vaos_sts_t;

endpackage

// ===== sv/voice_allocator_oldest_steal.sv =====
// voice allocator with oldest-voice stealing, top level
//
// requests come on req (cmd, slot) with req_valid/req_stall; one result per
// request leaves on rsp with rsp_valid/rsp_stall. max_voices is written over
// cfg_valid/cfg_ready/cfg_data; the user must write it only while the block
// is idle, the block itself does not enforce this. cfg_ready is always 1.
// one request is in work at a time. with L the effective limit:
//   finish, stop-all, unused cmd: no scan
//   play: busy scan up to the lowest idle slot k
//   play with all L slots busy: busy scan over all L slots, then a stamp
//   memory sweep at one read per cycle
// the slot walk over active bits and the single stamp memory read port set
// the length of a request. the next request is taken once the block is idle
// again, even while the last result is still held by a stalled receiver; a
// result that is ready but cannot enter the output register waits in place.
// reset clears all active and stamp valid bits, the order counter, and sets
// max_voices to 10. no clearing pass follows, requests are taken at once.
`include "voice_allocator_oldest_steal_macros.svh"

module voice_allocator_oldest_steal #(
	parameter int VOICE_SLOTS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  vaos_pkg::vaos_req_t        req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output vaos_pkg::vaos_rsp_t        rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [vaos_pkg::CFG_W-1:0] cfg_data
);

	vaos_pkg::vaos_ctl_t ctl;
	vaos_pkg::vaos_sts_t sts;

	assign cfg_ready = 1'b1;

	vaos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	vaos_datapath #(
		.VOICE_SLOTS (VOICE_SLOTS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.req      (req),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.rsp      (rsp)
	);

	`VAOS_ASSERT_NOW(a_no_grant_fields, rsp_valid && !rsp.granted,
		!rsp.stolen && rsp.voice == '0, "ungranted result carries a voice")
	`VAOS_ASSERT_NOW(a_grant_playing, rsp_valid && rsp.granted,
		rsp.any_playing, "granted voice but nothing playing")
	`VAOS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall,
		req_stall, "request taken while one is in work")

endmodule

// ===== sv/vaos_datapath.sv =====
// voice allocator datapath: slot state, stamp memory, scan and result register
module vaos_datapath #(
	parameter int VOICE_SLOTS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vaos_pkg::vaos_ctl_t          ctl,
	output vaos_pkg::vaos_sts_t          sts,
	input  vaos_pkg::vaos_req_t          req,
	input  logic                         cfg_we,
	input  logic [vaos_pkg::CFG_W-1:0]   cfg_data,
	output vaos_pkg::vaos_rsp_t          rsp
);

	localparam int SCAN_DEPTH = (VOICE_SLOTS < vaos_pkg::PLAYER_CAP) ?
		VOICE_SLOTS : vaos_pkg::PLAYER_CAP;
	localparam int IDX_W = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;

	vaos_pkg::vaos_req_t               req_q;
	vaos_pkg::vaos_rsp_t               rsp_q;
	logic [vaos_pkg::CFG_W-1:0]        max_voices_q;
	logic [VOICE_SLOTS-1:0]            active_q;
	logic [VOICE_SLOTS-1:0]            act_nx;
	logic [SCAN_DEPTH-1:0]             scan_act;
	logic [SCAN_DEPTH-1:0]             stamp_vld_q;
	logic [vaos_pkg::STAMP_W-1:0]      stamp_mem [SCAN_DEPTH];
	logic [vaos_pkg::STAMP_W-1:0]      rd_data_q;
	logic                              rd_vld_q;
	logic                              rd_pend_q;
	logic [IDX_W-1:0]                  rd_idx_q;
	logic [vaos_pkg::STAMP_W-1:0]      rd_stamp;
	logic [vaos_pkg::STAMP_W-1:0]      best_stamp_q;
	logic [IDX_W-1:0]                  best_idx_q;
	logic                              stolen_q;
	logic [IDX_W-1:0]                  idx_q;
	logic [vaos_pkg::STAMP_W-1:0]      counter_q;
	logic [vaos_pkg::CFG_W-1:0]        eff;
	logic                              is_play;

	assign scan_act = active_q[SCAN_DEPTH-1:0];
	assign is_play  = (req_q.cmd == vaos_pkg::CMD_PLAY);
	assign rd_stamp = rd_vld_q ? rd_data_q : '0;

	// effective limit, clamped to 1..scan depth
	always_comb begin
		eff = max_voices_q;
		if (eff == '0) begin
			eff = vaos_pkg::CFG_W'(1);
		end
		if (eff > vaos_pkg::CFG_W'(SCAN_DEPTH)) begin
			eff = vaos_pkg::CFG_W'(SCAN_DEPTH);
		end
	end

	assign sts.is_play  = is_play;
	assign sts.cur_idle = !scan_act[idx_q];
	assign sts.idx_last = (idx_q == IDX_W'(eff - vaos_pkg::CFG_W'(1)));

	always_comb begin
		act_nx = active_q;
		case (req_q.cmd)
			vaos_pkg::CMD_PLAY: begin
				for (int i = 0; i < VOICE_SLOTS; i++) begin
					if (i == int'(best_idx_q)) act_nx[i] = 1'b1;
				end
			end
			vaos_pkg::CMD_FINISH: begin
				for (int i = 0; i < VOICE_SLOTS; i++) begin
					if (i == int'(req_q.slot)) act_nx[i] = 1'b0;
				end
			end
			vaos_pkg::CMD_STOP: begin
				act_nx = '0;
			end
			default: begin
				act_nx = active_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_voices_q <= vaos_pkg::MAX_VOICES_RESET;
			active_q     <= '0;
			stamp_vld_q  <= '0;
			counter_q    <= '0;
			rd_pend_q    <= 1'b0;
			idx_q        <= '0;
		end else begin
			if (cfg_we) begin
				max_voices_q <= cfg_data;
			end
			rd_pend_q <= ctl.rd_en;
			if (ctl.idx_clr) begin
				idx_q <= '0;
			end else if (ctl.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (ctl.commit) begin
				active_q <= act_nx;
				if (is_play) begin
					stamp_vld_q[best_idx_q] <= 1'b1;
					counter_q <= counter_q + vaos_pkg::STAMP_W'(1);
				end
			end
		end
	end

	// stamp memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (ctl.commit && is_play) begin
			stamp_mem[best_idx_q] <= counter_q;
		end
		if (ctl.rd_en) begin
			rd_data_q <= stamp_mem[idx_q];
			rd_vld_q  <= stamp_vld_q[idx_q];
			rd_idx_q  <= idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_req) begin
			req_q <= req;
		end
		if (ctl.pick_free) begin
			best_idx_q <= idx_q;
			stolen_q   <= 1'b0;
		end
		if (ctl.steal_mark) begin
			stolen_q <= 1'b1;
		end
		// lowest stamp wins, ties keep the lower slot
		if (rd_pend_q && (rd_idx_q == '0 || rd_stamp < best_stamp_q)) begin
			best_idx_q   <= rd_idx_q;
			best_stamp_q <= rd_stamp;
		end
		if (ctl.commit) begin
			rsp_q.granted     <= is_play;
			rsp_q.voice       <= is_play ? vaos_pkg::VOICE_W'(best_idx_q) : '0;
			rsp_q.stolen      <= is_play & stolen_q;
			rsp_q.any_playing <= |act_nx;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== sv/vaos_ctrl.sv =====
// voice allocator controller: request sequencing and result handshake
module vaos_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  vaos_pkg::vaos_sts_t sts,
	output vaos_pkg::vaos_ctl_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FREE,
		S_STEAL,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		ctl      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load_req = 1'b1;
					ctl.idx_clr  = 1'b1;
					state_nx     = S_FREE;
				end
			end
			S_FREE: begin
				if (!sts.is_play) begin
					state_nx = S_DONE;
				end else if (sts.cur_idle) begin
					ctl.pick_free = 1'b1;
					state_nx      = S_DONE;
				end else if (sts.idx_last) begin
					ctl.idx_clr    = 1'b1;
					ctl.steal_mark = 1'b1;
					state_nx       = S_STEAL;
				end else begin
					ctl.idx_inc = 1'b1;
				end
			end
			S_STEAL: begin
				ctl.rd_en = 1'b1;
				if (sts.idx_last) begin
					state_nx = S_DRAIN;
				end else begin
					ctl.idx_inc = 1'b1;
				end
			end
			S_DRAIN: begin
				state_nx = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					ctl.commit = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== bench/vaos_checker.sv =====
// voice allocator checker: predicts each result and compares it with the block's output
`timescale 1ns / 1ps

module vaos_checker #(
	parameter int SLOTS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_stall,
	input  vaos_pkg::vaos_req_t        req,
	input  logic                       rsp_valid,
	input  logic                       rsp_stall,
	input  vaos_pkg::vaos_rsp_t        rsp,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [vaos_pkg::CFG_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending
);

	logic [vaos_pkg::CFG_W-1:0]   max_voices_q;
	logic [SLOTS-1:0]             playing;
	logic [vaos_pkg::STAMP_W-1:0] start_stamp [SLOTS];
	logic [vaos_pkg::STAMP_W-1:0] next_stamp;
	vaos_pkg::vaos_rsp_t          voice_results_due [$];
	int                           errors;

	assign fail_count = errors;

	function automatic vaos_pkg::vaos_rsp_t allocate_voice(input vaos_pkg::vaos_req_t r);
		vaos_pkg::vaos_rsp_t o;
		int                  lim;
		int                  pick;
		bit                  found;
		o = '0;
		case (r.cmd)
			vaos_pkg::CMD_PLAY: begin
				lim = (max_voices_q == 0) ? 1 : int'(max_voices_q);
				if (lim > vaos_pkg::PLAYER_CAP) lim = vaos_pkg::PLAYER_CAP;
				if (lim > SLOTS) lim = SLOTS;
				found = 1'b0;
				pick = 0;
				for (int i = 0; i < lim; i++) begin
					if (!found && !playing[i]) begin
						pick = i;
						found = 1'b1;
					end
				end
				// all slots in range busy: take the oldest, lowest index on a tie
				if (!found) begin
					for (int i = 1; i < lim; i++) begin
						if (start_stamp[i] < start_stamp[pick]) pick = i;
					end
					o.stolen = 1'b1;
				end
				start_stamp[pick] = next_stamp;
				next_stamp = next_stamp + vaos_pkg::STAMP_W'(1);
				playing[pick] = 1'b1;
				o.granted = 1'b1;
				o.voice = pick[vaos_pkg::VOICE_W-1:0];
			end
			vaos_pkg::CMD_FINISH: begin
				if (int'(r.slot) < SLOTS) playing[r.slot] = 1'b0;
			end
			vaos_pkg::CMD_STOP: begin
				playing = '0;
			end
			default: ;
		endcase
		o.any_playing = |playing;
		return o;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		vaos_pkg::vaos_rsp_t want;
		if (!arst_n) begin
			max_voices_q = vaos_pkg::MAX_VOICES_RESET;
			playing = '0;
			for (int i = 0; i < SLOTS; i++) start_stamp[i] = '0;
			next_stamp = '0;
			voice_results_due.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (voice_results_due.size() == 0) begin
					$display("%0t: result with no request waiting, expected none, actual %0h",
						$time, rsp);
					errors++;
				end else begin
					want = voice_results_due.pop_front();
					check_field("granted", 8'(want.granted), 8'(rsp.granted));
					check_field("voice", 8'(want.voice), 8'(rsp.voice));
					check_field("stolen", 8'(want.stolen), 8'(rsp.stolen));
					check_field("any_playing", 8'(want.any_playing), 8'(rsp.any_playing));
				end
			end
			if (cfg_valid && cfg_ready) max_voices_q = cfg_data;
			if (req_valid && !req_stall) voice_results_due.push_back(allocate_voice(req));
			pending <= voice_results_due.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// testbench top for the voice allocator: clock, reset, requests, verdict
`timescale 1ns / 1ps

module tb_top;

	localparam int                         VOICE_SLOTS = 64;
	localparam logic [vaos_pkg::CMD_W-1:0] CMD_UNUSED  = 2'd3;
	localparam int                         PHASES      = 12;
	localparam int                         PHASE_ITEMS = 80;
	localparam int                         HOLD_CYCLES = 300;
	localparam int                         TAIL_CYCLES = 140;
	localparam longint                     TIMEOUT_NS  = 64'd12 * 64'd800_000;

	logic                       clk;
	logic                       arst_n;
	logic                       req_valid;
	logic                       req_stall;
	vaos_pkg::vaos_req_t        req;
	logic                       rsp_valid;
	logic                       rsp_stall;
	vaos_pkg::vaos_rsp_t        rsp;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [vaos_pkg::CFG_W-1:0] cfg_data;
	int                         fail_count;
	int                         pending;

	bit tx_idle_en;
	bit rx_idle_en;
	int hold_offs_wanted;
	int hold_offs_done;

	voice_allocator_oldest_steal #(
		.VOICE_SLOTS(VOICE_SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	vaos_checker #(
		.SLOTS(VOICE_SLOTS)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

	function automatic vaos_pkg::vaos_req_t req_of(input logic [vaos_pkg::CMD_W-1:0] cmd,
		input int slot);
		vaos_pkg::vaos_req_t r;
		r.cmd = cmd;
		r.slot = slot[vaos_pkg::SLOT_W-1:0];
		return r;
	endfunction

	// mostly plays so the pool fills and stealing happens, finishes mostly in range
	function automatic vaos_pkg::vaos_req_t random_req(input int lim);
		vaos_pkg::vaos_req_t r;
		int                  span;
		int                  roll;
		span = (lim < 1) ? 1 : ((lim > vaos_pkg::PLAYER_CAP) ? vaos_pkg::PLAYER_CAP : lim);
		roll = $urandom_range(0, 99);
		r.slot = vaos_pkg::SLOT_W'($urandom_range(0, 63));
		if (span > 16) begin
			r.cmd = (roll < 80) ? vaos_pkg::CMD_PLAY : (roll < 95) ? vaos_pkg::CMD_FINISH :
				(roll < 96) ? vaos_pkg::CMD_STOP : CMD_UNUSED;
		end else begin
			r.cmd = (roll < 55) ? vaos_pkg::CMD_PLAY : (roll < 85) ? vaos_pkg::CMD_FINISH :
				(roll < 92) ? vaos_pkg::CMD_STOP : CMD_UNUSED;
		end
		if (r.cmd == vaos_pkg::CMD_FINISH && $urandom_range(0, 3) != 0)
			r.slot = vaos_pkg::SLOT_W'($urandom_range(0, span - 1));
		return r;
	endfunction

	task automatic send_req(input vaos_pkg::vaos_req_t r);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_limit(input int lim);
		settle();
		cfg_data <= lim[vaos_pkg::CFG_W-1:0];
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver side: random stall bursts, plus long hold-offs on request
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_offs_done != hold_offs_wanted) begin
				hold_offs_done++;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		int phase_limit [PHASES];
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		hold_offs_wanted = 0;
		hold_offs_done = 0;
		phase_limit = '{3, 1, 10, 64, 127, 0, 5, 80, 2, 0, 64, 9};
		phase_limit[9] = $urandom_range(0, 127);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default limit, fill, steal, free and reuse
		send_req(req_of(vaos_pkg::CMD_FINISH, 63));
		send_req(req_of(CMD_UNUSED, 0));
		repeat (10) send_req(req_of(vaos_pkg::CMD_PLAY, 0));
		send_req(req_of(vaos_pkg::CMD_PLAY, 63));
		send_req(req_of(vaos_pkg::CMD_FINISH, 5));
		send_req(req_of(vaos_pkg::CMD_PLAY, 0));
		send_req(req_of(vaos_pkg::CMD_STOP, 0));
		// zero limit acts as one
		write_limit(0);
		send_req(req_of(vaos_pkg::CMD_PLAY, 0));
		send_req(req_of(vaos_pkg::CMD_PLAY, 0));
		// limit above cap saturates
		write_limit(127);
		send_req(req_of(vaos_pkg::CMD_PLAY, 0));
		send_req(req_of(vaos_pkg::CMD_PLAY, 0));
		// slots above a lowered limit stay active
		write_limit(1);
		send_req(req_of(vaos_pkg::CMD_FINISH, 0));
		send_req(req_of(vaos_pkg::CMD_PLAY, 0));
		send_req(req_of(vaos_pkg::CMD_FINISH, 0));
		send_req(req_of(vaos_pkg::CMD_STOP, 63));

		for (int p = 0; p < PHASES; p++) begin
			write_limit(phase_limit[p]);
			tx_idle_en = (p < PHASES - 2) && (p % 3 != 2);
			rx_idle_en = tx_idle_en;
			if (p == 1 || p == 6) hold_offs_wanted++;
			repeat (PHASE_ITEMS) send_req(random_req(phase_limit[p]));
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/vaos_pkg.sv
sv/vaos_datapath.sv
sv/vaos_ctrl.sv
sv/voice_allocator_oldest_steal.sv
bench/vaos_checker.sv
bench/tb_top.sv
